// ----- hdl/ktl_pkg.sv -----
// ----------------------------------------------------------------------------
// ktl_pkg
// shared types, widths and code tables for the kinsoku text layout block
// ----------------------------------------------------------------------------
package ktl_pkg;

  localparam int CODE_W      = 16;
  localparam int CELL_IDX_W  = 7;
  localparam int COL_W       = 5;
  localparam int ROW_W       = 5;
  localparam int CNT_W       = 8;
  localparam int IDX_W       = CNT_W + 1;
  localparam int PAD_W       = 6;
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W      = $clog2(MAX_RESULTS);

  localparam int COLUMNS_DEF = 16;
  localparam int ROWS_DEF    = 8;
  localparam int CELL_CAP_MAX = 128;

  localparam logic [CODE_W-1:0] NAME_END_RESET = 16'h817A;

  localparam int FRONT_N = 34;
  localparam int BACK_N  = 5;

  // codes that must not open a line
  localparam logic [CODE_W-1:0] FRONT_TABLE [FRONT_N] = '{
    16'h82E1, 16'h82E3, 16'h82E5, 16'h82C1, 16'h8142, 16'h8141, 16'h8145, 16'h8163,
    16'h8184, 16'h8178, 16'h8176, 16'h816A, 16'h816E, 16'h8148, 16'h8149, 16'h817C,
    16'h815B, 16'h8383, 16'h8385, 16'h8387, 16'h8362, 16'h8396, 16'h829F, 16'h82A1,
    16'h82A3, 16'h82A5, 16'h82A7, 16'h8340, 16'h8342, 16'h8344, 16'h8346, 16'h8348,
    16'h8144, 16'h8160
  };

  // openers that must not close a line
  localparam logic [CODE_W-1:0] BACK_TABLE [BACK_N] = '{
    16'h8183, 16'h8177, 16'h8175, 16'h816D, 16'h8169
  };

  typedef enum logic [1:0] {
    OFF_ZERO  = 2'b00,
    OFF_PLUS  = 2'b01,
    OFF_MINUS = 2'b11
  } off_t;

  typedef struct packed {
    off_t             off;
    logic [PAD_W-1:0] amt;
  } cnt_req_t;

  typedef struct packed {
    logic [CELL_IDX_W-1:0] idx;
    logic                  ovf;
    logic [CNT_W-1:0]      sum;
  } cnt_rsp_t;

  typedef struct packed {
    logic front;
    logic back;
  } cls_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PULL = 5'b00010,
    ST_BACK = 5'b00100,
    ST_NORM = 5'b01000,
    ST_PAD  = 5'b10000
  } state_t;

endpackage

// ----- hdl/ktl_class.sv -----
// ----------------------------------------------------------------------------
// ktl_class
// matches a character code against the line-start and line-end tables
// ----------------------------------------------------------------------------
module ktl_class (
  input  logic [ktl_pkg::CODE_W-1:0] code,
  output ktl_pkg::cls_t              cls
);

  always_comb begin
    cls = '0;
    for (int i = 0; i < ktl_pkg::FRONT_N; i++) begin
      if (code == ktl_pkg::FRONT_TABLE[i]) begin
        cls.front = 1'b1;
      end
    end
    for (int j = 0; j < ktl_pkg::BACK_N; j++) begin
      if (code == ktl_pkg::BACK_TABLE[j]) begin
        cls.back = 1'b1;
      end
    end
  end

endmodule

// ----- hdl/ktl_cnt_unit.sv -----
// ----------------------------------------------------------------------------
// ktl_cnt_unit
// shared cell count arithmetic: target index, capacity check, saturating add
// ----------------------------------------------------------------------------
module ktl_cnt_unit #(
  parameter int COLUMNS = ktl_pkg::COLUMNS_DEF,
  parameter int ROWS    = ktl_pkg::ROWS_DEF
) (
  input  logic [ktl_pkg::CNT_W-1:0] cnt,
  input  ktl_pkg::cnt_req_t         req,
  output ktl_pkg::cnt_rsp_t         rsp
);

  localparam int CAP_RAW = COLUMNS * ROWS;
  localparam int CAP     = (CAP_RAW > ktl_pkg::CELL_CAP_MAX) ? ktl_pkg::CELL_CAP_MAX : CAP_RAW;

  logic [ktl_pkg::IDX_W-1:0] idx_full;
  logic [ktl_pkg::IDX_W-1:0] sum_full;

  always_comb begin
    case (req.off)
      ktl_pkg::OFF_PLUS:  idx_full = {1'b0, cnt} + ktl_pkg::IDX_W'(1);
      ktl_pkg::OFF_MINUS: idx_full = {1'b0, cnt} - ktl_pkg::IDX_W'(1);
      default:            idx_full = {1'b0, cnt};
    endcase
  end

  assign sum_full = {1'b0, cnt} + ktl_pkg::IDX_W'(req.amt);

  always_comb begin
    rsp.ovf = (idx_full >= ktl_pkg::IDX_W'(CAP));
    rsp.idx = rsp.ovf ? '0 : idx_full[ktl_pkg::CELL_IDX_W-1:0];
    // count saturates at its full scale
    rsp.sum = sum_full[ktl_pkg::CNT_W] ? '1 : sum_full[ktl_pkg::CNT_W-1:0];
  end

endmodule

// ----- hdl/kinsoku_text_layout_core.sv -----
// ----------------------------------------------------------------------------
// kinsoku_text_layout_core: one item at a time; a plain character, a pushed opener,
// a pulled-back closer and padding write their cells from the shared count unit,
// one cell write per cycle while the output is not stalled; an accepted item goes through
// the state register to the output registers. sync reset: position zeroed, name-end code 0x817A
// ----------------------------------------------------------------------------
module kinsoku_text_layout_core #(
  parameter int COLUMNS = ktl_pkg::COLUMNS_DEF,
  parameter int ROWS    = ktl_pkg::ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [ktl_pkg::CODE_W-1:0]         in_char_code,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ktl_pkg::CELL_IDX_W-1:0]     out_cell_index,
  output logic [ktl_pkg::CODE_W-1:0]         out_cell_code,
  output logic                               out_overflow,
  output logic                               out_last,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ktl_pkg::CODE_W-1:0]         cfg_data
);

  localparam logic [ktl_pkg::PAD_W-1:0] COLS_P   = ktl_pkg::PAD_W'(COLUMNS);
  localparam logic [ktl_pkg::COL_W-1:0] COL_LAST = ktl_pkg::COL_W'(COLUMNS - 1);
  localparam logic [ktl_pkg::NRES_W-1:0] NRES_LAST = ktl_pkg::NRES_W'(ktl_pkg::MAX_RESULTS - 1);

  ktl_pkg::state_t state_r, state_nxt;
  logic [1:0]                      step_r, step_nxt;
  logic [ktl_pkg::CODE_W-1:0]      code_r, code_nxt;
  logic [ktl_pkg::COL_W-1:0]       col_r, col_nxt;
  logic [ktl_pkg::ROW_W-1:0]       row_r, row_nxt;
  logic [ktl_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [ktl_pkg::CODE_W-1:0]      lv_r, lv_nxt;
  logic [ktl_pkg::CODE_W-1:0]      nec_r;
  logic [ktl_pkg::PAD_W-1:0]       pad_r, pad_nxt;
  logic [ktl_pkg::NRES_W-1:0]      nres_r, nres_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [ktl_pkg::CELL_IDX_W-1:0]  out_idx_r;
  logic [ktl_pkg::CODE_W-1:0]      out_code_r;
  logic                            out_ovf_r;
  logic                            out_last_r;

  ktl_pkg::cls_t     cls;
  ktl_pkg::cnt_req_t req;
  ktl_pkg::cnt_rsp_t rsp;

  logic                            out_free;
  logic                            emit;
  logic [ktl_pkg::CODE_W-1:0]      e_code;
  logic                            e_last;
  logic [ktl_pkg::PAD_W-1:0]       col_inc;
  logic [ktl_pkg::ROW_W-1:0]       row_up;

  ktl_class u_class (
    .code (in_char_code),
    .cls  (cls)
  );

  ktl_cnt_unit #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cnt (
    .cnt (cnt_r),
    .req (req),
    .rsp (rsp)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ktl_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign col_inc   = {1'b0, col_r} + ktl_pkg::PAD_W'(1);
  assign row_up    = (row_r == '1) ? row_r : row_r + ktl_pkg::ROW_W'(1);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    code_nxt  = code_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    cnt_nxt   = cnt_r;
    lv_nxt    = lv_r;
    pad_nxt   = pad_r;
    nres_nxt  = nres_r;
    req.off   = ktl_pkg::OFF_ZERO;
    req.amt   = '0;
    emit      = 1'b0;
    e_code    = '0;
    e_last    = 1'b0;

    case (state_r)
      ktl_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd) begin
            col_nxt = '0;
            row_nxt = '0;
            cnt_nxt = '0;
            lv_nxt  = '0;
          end else begin
            code_nxt = in_char_code;
            step_nxt = '0;
            if (col_r == '0 && cnt_r != '0 && cls.front) begin
              state_nxt = ktl_pkg::ST_PULL;
            end else if (col_r == COL_LAST && cls.back) begin
              state_nxt = ktl_pkg::ST_BACK;
            end else begin
              state_nxt = ktl_pkg::ST_NORM;
            end
          end
        end
      end

      // previous cell moves down, old cell blanked, closer follows it
      ktl_pkg::ST_PULL: begin
        if (out_free) begin
          emit = 1'b1;
          case (step_r)
            2'd0: begin
              e_code   = lv_r;
              step_nxt = 2'd1;
            end
            2'd1: begin
              req.off  = ktl_pkg::OFF_MINUS;
              step_nxt = 2'd2;
            end
            default: begin
              req.off   = ktl_pkg::OFF_PLUS;
              req.amt   = ktl_pkg::PAD_W'(2);
              e_code    = code_r;
              e_last    = 1'b1;
              cnt_nxt   = rsp.sum;
              col_nxt   = ktl_pkg::COL_W'(2);
              lv_nxt    = code_r;
              state_nxt = ktl_pkg::ST_IDLE;
            end
          endcase
        end
      end

      // opener at the last column goes to the next line behind a blank
      ktl_pkg::ST_BACK: begin
        if (out_free) begin
          emit = 1'b1;
          if (step_r == 2'd0) begin
            step_nxt = 2'd1;
          end else begin
            req.off   = ktl_pkg::OFF_PLUS;
            req.amt   = ktl_pkg::PAD_W'(2);
            e_code    = code_r;
            e_last    = 1'b1;
            cnt_nxt   = rsp.sum;
            row_nxt   = row_up;
            col_nxt   = ktl_pkg::COL_W'(1);
            lv_nxt    = code_r;
            state_nxt = ktl_pkg::ST_IDLE;
          end
        end
      end

      ktl_pkg::ST_NORM: begin
        if (out_free) begin
          emit    = 1'b1;
          e_code  = code_r;
          req.amt = ktl_pkg::PAD_W'(1);
          cnt_nxt = rsp.sum;
          lv_nxt  = code_r;
          if (col_inc == COLS_P) begin
            col_nxt   = '0;
            row_nxt   = row_up;
            e_last    = 1'b1;
            state_nxt = ktl_pkg::ST_IDLE;
          end else if (code_r == nec_r) begin
            pad_nxt   = COLS_P - col_inc;
            nres_nxt  = ktl_pkg::NRES_W'(1);
            state_nxt = ktl_pkg::ST_PAD;
          end else begin
            col_nxt   = col_inc[ktl_pkg::COL_W-1:0];
            e_last    = 1'b1;
            state_nxt = ktl_pkg::ST_IDLE;
          end
        end
      end

      // blank the rest of the line; once the result limit is hit the
      // remaining pad cells are counted in one add
      ktl_pkg::ST_PAD: begin
        if (out_free) begin
          emit = 1'b1;
          if (pad_r == ktl_pkg::PAD_W'(1) || nres_r == NRES_LAST) begin
            e_last    = 1'b1;
            req.amt   = pad_r;
            cnt_nxt   = rsp.sum;
            lv_nxt    = '0;
            col_nxt   = '0;
            row_nxt   = row_up;
            state_nxt = ktl_pkg::ST_IDLE;
          end else begin
            req.amt  = ktl_pkg::PAD_W'(1);
            cnt_nxt  = rsp.sum;
            pad_nxt  = pad_r - ktl_pkg::PAD_W'(1);
            nres_nxt = nres_r + ktl_pkg::NRES_W'(1);
          end
        end
      end

      default: begin
        state_nxt = ktl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ktl_pkg::ST_IDLE;
      step_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      lv_r        <= '0;
      nec_r       <= ktl_pkg::NAME_END_RESET;
      pad_r       <= '0;
      nres_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      cnt_r       <= cnt_nxt;
      lv_r        <= lv_nxt;
      pad_r       <= pad_nxt;
      nres_r      <= nres_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        nec_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    if (emit) begin
      out_idx_r  <= rsp.idx;
      out_ovf_r  <= rsp.ovf;
      out_code_r <= e_code;
      out_last_r <= e_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_index = out_idx_r;
  assign out_cell_code  = out_code_r;
  assign out_overflow   = out_ovf_r;
  assign out_last       = out_last_r;

endmodule
